@@ hw/rtl/bitmap_window_validity_check_assert.svh @@
// ----------------------------------------------------------------------------
// bitmap_window_validity_check_assert.svh
// Assertion macros used by the checker of the validity check block.
// ----------------------------------------------------------------------------
`ifndef BITMAP_WINDOW_VALIDITY_CHECK_ASSERT_SVH
`define BITMAP_WINDOW_VALIDITY_CHECK_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define BWVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BWVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/bwvc_pkg.sv @@
// ----------------------------------------------------------------------------
// bwvc_pkg
// Widths, field positions and codes of the bitmap window validity check.
// ----------------------------------------------------------------------------
package bwvc_pkg;

  // Sizes
  localparam int MAX_WORDS   = 1024;
  localparam int WORD_BITS   = 64;
  localparam int ADDR_W      = $clog2(MAX_WORDS);
  localparam int POS_W       = 17;
  localparam int OFF_W       = $clog2(WORD_BITS);
  localparam int TAKE_W      = OFF_W + 1;

  // Input tdata layout: word_addr, word_data, position, length
  localparam int IN_IDX_LO   = 0;
  localparam int IN_DATA_LO  = IN_IDX_LO + ADDR_W;
  localparam int IN_POS_LO   = IN_DATA_LO + WORD_BITS;
  localparam int IN_LEN_LO   = IN_POS_LO + POS_W;
  localparam int IN_USED_W   = IN_LEN_LO + POS_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout: is_valid, word_out
  localparam int OUT_USED_W  = 1 + WORD_BITS;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_DATA_W  = POS_W;

  typedef enum logic [1:0] {
    ACT_WRITE     = 2'd0,
    ACT_READ      = 2'd1,
    ACT_TEST_BASE = 2'd2,
    ACT_TEST_WIN  = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    REG_BASE_COUNT     = 1'b0,
    REG_BITMAP_PRESENT = 1'b1
  } reg_index_t;

endpackage

@@ hw/rtl/bitmap_window_validity_check.sv @@
// ----------------------------------------------------------------------------
// bitmap_window_validity_check
// Per-base validity bitmap with word write/read, base test and window test.
// ----------------------------------------------------------------------------
// One transaction at a time. A word write goes from acceptance straight to
// the result, while a masked read and an in-range single-base test first
// read one word in the walk state. A window test that passes the range checks
// walks the bitmap one word per cycle through the single read port of the
// store, one 64-bit word of the window after another, up to the last word it
// touches or the first word that fails. Range failures and zero-length windows
// go from acceptance straight to the result. The input is ready again as soon
// as the result sits in the output register, even while it waits to be taken.
// The store is not cleared: words must be written before use.
// ----------------------------------------------------------------------------
module bitmap_window_validity_check
  import bwvc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // Input stream
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // word_addr[9:0], word_data[73:10], position[90:74], length[107:91]
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  // action[1:0]
  input  logic [1:0]              in_tuser,
  // Result stream
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // is_valid[0], word_out[64:1]
  output logic [OUT_TDATA_W-1:0]  out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Mask with bits below n set, n from 0 to 64
  function automatic logic [WORD_BITS-1:0] ones_below(input logic [TAKE_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (TAKE_W'(i) < n);
    end
    return m;
  endfunction

  // Configuration registers
  logic [POS_W-1:0]       base_count_r;
  logic                   present_r;

  // Sequencer and walk registers
  state_t                 state_r, state_nxt;
  action_t                act_r, act_nxt;
  logic [ADDR_W-1:0]      word_idx_r, word_idx_nxt;
  logic [OFF_W-1:0]       off_r, off_nxt;
  logic [POS_W-1:0]       left_r, left_nxt;
  logic                   res_valid_r, res_valid_nxt;
  logic [WORD_BITS-1:0]   res_word_r, res_word_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Bitmap store
  logic [WORD_BITS-1:0]   mem [MAX_WORDS];
  logic [WORD_BITS-1:0]   rd_data_r;
  logic [ADDR_W-1:0]      rd_addr;

  // Input fields
  action_t                in_act;
  logic [ADDR_W-1:0]      in_idx;
  logic [WORD_BITS-1:0]   in_word;
  logic [POS_W-1:0]       in_pos;
  logic [POS_W-1:0]       in_len;
  logic                   in_fire;

  // Accept-time range check
  logic [POS_W-1:0]       win_len;
  logic [POS_W-1:0]       span;

  // Walk datapath
  logic [TAKE_W-1:0]      room;
  logic [TAKE_W-1:0]      take;
  logic [TAKE_W-1:0]      end_bit;
  logic [WORD_BITS-1:0]   need;
  logic [WORD_BITS-1:0]   tail;
  logic [WORD_BITS-1:0]   eff;
  logic [POS_W-1:0]       left_dec;
  logic                   chunk_ok;

  assign in_act   = action_t'(in_tuser);
  assign in_idx   = in_tdata[IN_IDX_LO  +: ADDR_W];
  assign in_word  = in_tdata[IN_DATA_LO +: WORD_BITS];
  assign in_pos   = in_tdata[IN_POS_LO  +: POS_W];
  assign in_len   = in_tdata[IN_LEN_LO  +: POS_W];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_count_r <= '0;
      present_r    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_BASE_COUNT:     base_count_r <= cfg_data;
        REG_BITMAP_PRESENT: present_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_fire && in_act == ACT_WRITE) begin
      mem[in_idx] <= in_word;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Read address: first word at acceptance, then the following word
  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = (in_act == ACT_READ) ? in_idx : in_pos[OFF_W +: ADDR_W];
    end else begin
      rd_addr = word_idx_r + ADDR_W'(1);
    end
  end

  // Window range check; a single-base test is a window of one
  assign win_len = (in_act == ACT_TEST_BASE) ? POS_W'(1) : in_len;
  assign span    = base_count_r - in_pos;

  // Tail mask of the base count for the current word
  always_comb begin
    if ({1'b0, word_idx_r} < base_count_r[POS_W-1:OFF_W]) begin
      tail = '1;
    end else if ({1'b0, word_idx_r} == base_count_r[POS_W-1:OFF_W]) begin
      tail = ones_below({1'b0, base_count_r[OFF_W-1:0]});
    end else begin
      tail = '0;
    end
  end

  assign eff = present_r ? (rd_data_r & tail) : tail;

  // Chunk of the window inside the current word
  assign room     = TAKE_W'(WORD_BITS) - {1'b0, off_r};
  assign take     = (left_r < POS_W'(room)) ? left_r[TAKE_W-1:0] : room;
  assign end_bit  = {1'b0, off_r} + take;
  assign need     = ~ones_below({1'b0, off_r}) & ones_below(end_bit);
  assign chunk_ok = ((eff & need) == need);
  assign left_dec = left_r - POS_W'(take);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    word_idx_nxt  = word_idx_r;
    off_nxt       = off_r;
    left_nxt      = left_r;
    res_valid_nxt = res_valid_r;
    res_word_nxt  = res_word_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Output register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt       = in_act;
          word_idx_nxt  = rd_addr;
          off_nxt       = in_pos[OFF_W-1:0];
          left_nxt      = win_len;
          res_valid_nxt = 1'b0;
          res_word_nxt  = '0;
          case (in_act) inside
            ACT_WRITE: state_nxt = S_DONE;
            ACT_READ:  state_nxt = S_WALK;
            ACT_TEST_BASE, ACT_TEST_WIN: begin
              if (in_pos > base_count_r) begin
                state_nxt = S_DONE;
              end else if (win_len == '0) begin
                res_valid_nxt = 1'b1;
                state_nxt     = S_DONE;
              end else if (win_len > span) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        if (act_r == ACT_READ) begin
          res_word_nxt = eff;
          state_nxt    = S_DONE;
        end else if (!chunk_ok || left_dec == '0) begin
          res_valid_nxt = chunk_ok;
          state_nxt     = S_DONE;
        end else begin
          left_nxt     = left_dec;
          off_nxt      = '0;
          word_idx_nxt = rd_addr;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({res_word_r, res_valid_r});
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    word_idx_r  <= word_idx_nxt;
    off_r       <= off_nxt;
    left_r      <= left_nxt;
    res_valid_r <= res_valid_nxt;
    res_word_r  <= res_word_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

@@ hw/rtl/bwvc_checker.sv @@
// ----------------------------------------------------------------------------
// bwvc_checker
// Port-level assertions for the bitmap window validity check.
// ----------------------------------------------------------------------------
`include "bitmap_window_validity_check_assert.svh"

module bwvc_checker
  import bwvc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    in_tready,
  input  logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic [OUT_TDATA_W-1:0]  out_tdata
);

  logic out_stall;
  logic in_accept;
  logic out_word_nz;

  assign out_stall   = out_tvalid && !out_tready;
  assign in_accept   = in_tvalid && in_tready;
  assign out_word_nz = (out_tdata[WORD_BITS:1] != '0);

  // A stalled result holds
  `BWVC_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "stalled result changed")

  // One transaction at a time: busy right after acceptance
  `BWVC_ASSERT_NEXT(a_busy_after_accept, in_accept, !in_tready, "input ready after accept")

  // A read result never claims a valid test
  `BWVC_ASSERT_ALWAYS(a_word_or_flag, !(out_tvalid && out_tdata[0] && out_word_nz), "word and flag both set")

endmodule

bind bitmap_window_validity_check bwvc_checker u_bwvc_checker (.*);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap window validity check.
// ----------------------------------------------------------------------------
// Word writes, masked reads, single-base tests and window tests go in on the
// input stream. A scoreboard keeps its own copy of the bitmap and of the two
// registers and works out each result when its input transaction is taken.
// Each result is then compared against the oldest outstanding one.
// A short directed pass covers the range edges. Six random phases follow,
// each with a chosen base count and bitmap mode and with varying idle
// pressure on both streams. Where the bitmap is in use, reads and tests only
// touch bitmap words with bases below the count that were written earlier.
// ----------------------------------------------------------------------------
module testbench;
  import bwvc_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_ITEMS   = 290;
  localparam int CLUSTER_WORDS = 8;
  localparam int MAX_POS       = 65536;
  localparam int MAX_REPORTS   = 10;

  // One input transaction, unpacked
  typedef struct {
    action_t              act;
    logic [ADDR_W-1:0]    idx;
    logic [WORD_BITS-1:0] data;
    logic [POS_W-1:0]     pos;
    logic [POS_W-1:0]     len;
  } bitmap_op_t;

  // Result owed for one accepted transaction
  typedef struct {
    action_t              act;
    bit                   is_valid;
    bit [WORD_BITS-1:0]   word_out;
  } check_outcome_t;

  // --------------------------------------------------------------------------
  // Scoreboard: bitmap copy, register copy and outstanding results
  // --------------------------------------------------------------------------
  class validity_scoreboard;
    bit [WORD_BITS-1:0] store_words [MAX_WORDS];
    bit                 planned [MAX_WORDS];
    int                 count;
    bit                 present;
    check_outcome_t     outcomes_due [$];
    int                 mismatches;
    int                 results_seen;
    int                 valid_results;
    int                 per_action [4];

    function new();
      count         = 0;
      present       = 1'b1;
      mismatches    = 0;
      results_seen  = 0;
      valid_results = 0;
      foreach (per_action[i]) per_action[i] = 0;
    endfunction

    function bit [WORD_BITS-1:0] ones_below(int n);
      if (n <= 0) return '0;
      if (n >= WORD_BITS) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    // Bases of word w that lie below the count
    function bit [WORD_BITS-1:0] tail_mask(int w);
      if (w >= (count + WORD_BITS - 1) / WORD_BITS) return '0;
      return ones_below(count - w * WORD_BITS);
    endfunction

    // Validity word as the block sees it under the current registers
    function bit [WORD_BITS-1:0] usable_word(int w);
      bit [WORD_BITS-1:0] tail;
      tail = tail_mask(w);
      if (tail == '0 || !present) return tail;
      return store_words[w] & tail;
    endfunction

    function bit window_pass(int start, int span);
      int                 cursor;
      int                 left;
      int                 take;
      bit [WORD_BITS-1:0] need;
      if (start > count) return 1'b0;
      if (span == 0) return 1'b1;
      if (span > count - start) return 1'b0;
      cursor = start;
      left   = span;
      // walk the window one word at a time
      while (left != 0) begin
        take = WORD_BITS - cursor % WORD_BITS;
        if (left < take) take = left;
        need = ones_below(take) << (cursor % WORD_BITS);
        if ((usable_word(cursor / WORD_BITS) & need) != need) return 1'b0;
        cursor += take;
        left   -= take;
      end
      return 1'b1;
    endfunction

    // True if op would look at a bitmap word that holds nothing yet, while the bitmap is in use
    function bit reads_unwritten(bitmap_op_t op);
      int pos;
      int len;
      pos = int'(op.pos);
      len = int'(op.len);
      if (!present) return 1'b0;
      case (op.act)
        ACT_READ: begin
          return tail_mask(int'(op.idx)) != '0 && !planned[op.idx];
        end
        ACT_TEST_BASE: begin
          if (pos < count) return !planned[pos / WORD_BITS];
        end
        ACT_TEST_WIN: begin
          if (len != 0 && pos <= count && len <= count - pos) begin
            for (int w = pos / WORD_BITS; w <= (pos + len - 1) / WORD_BITS; w++)
              if (!planned[w]) return 1'b1;
          end
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void note_input(action_t act, logic [IN_TDATA_W-1:0] tdata);
      logic [ADDR_W-1:0]    idx;
      logic [WORD_BITS-1:0] data;
      int                   pos;
      int                   len;
      bit [WORD_BITS-1:0]   w;
      check_outcome_t       res;
      idx  = tdata[IN_IDX_LO +: ADDR_W];
      data = tdata[IN_DATA_LO +: WORD_BITS];
      pos  = int'(tdata[IN_POS_LO +: POS_W]);
      len  = int'(tdata[IN_LEN_LO +: POS_W]);
      res.act      = act;
      res.is_valid = 1'b0;
      res.word_out = '0;
      case (act)
        ACT_WRITE: store_words[idx] = data;
        ACT_READ:  res.word_out = usable_word(int'(idx));
        ACT_TEST_BASE: begin
          if (pos < count) begin
            w = usable_word(pos / WORD_BITS);
            res.is_valid = w[pos % WORD_BITS];
          end
        end
        default: res.is_valid = window_pass(pos, len);
      endcase
      per_action[int'(act)]++;
      outcomes_due.push_back(res);
    endfunction

    function void report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", what);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      logic                 got_valid;
      logic [WORD_BITS-1:0] got_word;
      check_outcome_t       want;
      got_valid = tdata[0];
      got_word  = tdata[WORD_BITS:1];
      results_seen++;
      if (outcomes_due.size() == 0) begin
        report_mismatch($sformatf("result with none outstanding: is_valid %0b word_out %h",
                                  got_valid, got_word));
        return;
      end
      want = outcomes_due.pop_front();
      if (want.is_valid) valid_results++;
      if (got_valid !== want.is_valid)
        report_mismatch($sformatf("%s is_valid: expected %0b, got %0b",
                                  want.act.name(), want.is_valid, got_valid));
      if (got_word !== want.word_out)
        report_mismatch($sformatf("%s word_out: expected %h, got %h",
                                  want.act.name(), want.word_out, got_word));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals, clock and block
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [0:0]             cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int send_idle_pct;
  int recv_idle_pct;

  validity_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  bitmap_window_validity_check dut (.*);

  // Result side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor both streams
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) sb.note_input(action_t'(in_tuser), in_tdata);
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic bitmap_op_t op_of(action_t act, int idx, logic [WORD_BITS-1:0] data,
                                       int pos, int len);
    bitmap_op_t op;
    op.act  = act;
    op.idx  = ADDR_W'(idx);
    op.data = data;
    op.pos  = POS_W'(pos);
    op.len  = POS_W'(len);
    return op;
  endfunction

  task automatic send_op(bitmap_op_t op);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[IN_IDX_LO +: ADDR_W]     = op.idx;
    word[IN_DATA_LO +: WORD_BITS] = op.data;
    word[IN_POS_LO +: POS_W]      = op.pos;
    word[IN_LEN_LO +: POS_W]      = op.len;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    if (op.act == ACT_WRITE) sb.planned[op.idx] = 1'b1;
    in_tvalid <= 1'b1;
    in_tuser  <= op.act;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Wait until every result is back and the block has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outcomes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(int bases, bit use_bitmap);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BASE_COUNT;
    cfg_data  <= bases[POS_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_BITMAP_PRESENT;
    cfg_data  <= CFG_DATA_W'(use_bitmap);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    sb.count   = bases;
    sb.present = use_bitmap;
  endtask

  // Random transaction aimed at a cluster of words and at the count edge
  function automatic bitmap_op_t random_op(int clus_lo);
    bitmap_op_t op;
    int         pick;
    int         start;
    int         span;
    for (int tries = 0; tries < 20; tries++) begin
      op.idx  = ADDR_W'($urandom);
      op.data = {$urandom, $urandom};
      op.pos  = POS_W'($urandom_range(0, MAX_POS));
      op.len  = POS_W'($urandom_range(0, MAX_POS));
      pick    = $urandom_range(0, 99);
      op.act  = pick < 30 ? ACT_WRITE : pick < 45 ? ACT_READ :
                pick < 65 ? ACT_TEST_BASE : ACT_TEST_WIN;
      if ($urandom_range(0, 99) < 80)
        op.idx = ADDR_W'(clus_lo + int'($urandom_range(0, CLUSTER_WORDS - 1)));
      // start position: inside the cluster, around the count, or anywhere
      pick = $urandom_range(0, 99);
      if (pick < 70) start = clus_lo * WORD_BITS + $urandom_range(0, CLUSTER_WORDS * WORD_BITS - 1);
      else if (pick < 85) start = sb.count + int'($urandom_range(0, 4)) - 2;
      else start = int'(op.pos);
      if (start < 0) start = 0;
      if (start > MAX_POS) start = MAX_POS;
      op.pos = POS_W'(start);
      // length: short, medium, ending near the count, or anywhere
      pick = $urandom_range(0, 99);
      if (pick < 60) span = $urandom_range(0, 200);
      else if (pick < 80) span = $urandom_range(0, 700);
      else if (pick < 97) span = sb.count - start + int'($urandom_range(0, 2)) - 1;
      else span = int'(op.len);
      if (span < 0) span = 0;
      if (span > MAX_POS) span = MAX_POS;
      op.len = POS_W'(span);
      if (op.act == ACT_WRITE) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) op.data = '1;
        else if (pick < 65) op.data = ~(64'd1 << $urandom_range(0, WORD_BITS - 1));
        else if (pick < 75) op.data = '0;
        return op;
      end
      if (!sb.reads_unwritten(op)) return op;
    end
    // nothing legal found: fill in a cluster word instead
    return op_of(ACT_WRITE, clus_lo + $urandom_range(0, CLUSTER_WORDS - 1), '1, 0, 0);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int bases;
    int words;
    int clus_lo;
    bit use_bitmap;
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 47;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 200 bases, base 69 invalid, last word partly used
    write_config(200, 1'b1);
    send_op(op_of(ACT_WRITE, 0, '1, 0, 0));
    send_op(op_of(ACT_WRITE, 1, ~(64'd1 << 5), 0, 0));
    send_op(op_of(ACT_WRITE, 2, '1, 0, 0));
    send_op(op_of(ACT_WRITE, 3, '0, 0, 0));
    send_op(op_of(ACT_WRITE, MAX_WORDS - 1, '0, 0, 0));
    send_op(op_of(ACT_READ, 3, '0, 0, 0));
    send_op(op_of(ACT_WRITE, 3, '1, 0, 0));
    send_op(op_of(ACT_READ, 3, '0, 0, 0));
    send_op(op_of(ACT_READ, 0, '0, 0, 0));
    send_op(op_of(ACT_READ, MAX_WORDS - 1, '0, 0, 0));
    send_op(op_of(ACT_TEST_BASE, 0, '0, 0, 0));
    send_op(op_of(ACT_TEST_BASE, 0, '0, 69, 0));
    send_op(op_of(ACT_TEST_BASE, 0, '0, 199, 0));
    send_op(op_of(ACT_TEST_BASE, 0, '0, 200, 0));
    send_op(op_of(ACT_TEST_BASE, 0, '0, MAX_POS, 0));
    send_op(op_of(ACT_TEST_WIN, 0, '0, 0, 0));
    send_op(op_of(ACT_TEST_WIN, 0, '0, 200, 0));
    send_op(op_of(ACT_TEST_WIN, 0, '0, 201, 0));
    send_op(op_of(ACT_TEST_WIN, 0, '0, 0, 200));
    send_op(op_of(ACT_TEST_WIN, 0, '0, 70, 130));
    send_op(op_of(ACT_TEST_WIN, 0, '0, 60, 10));
    send_op(op_of(ACT_TEST_WIN, 0, '0, 150, 51));
    send_op(op_of(ACT_TEST_WIN, 0, '0, MAX_POS, MAX_POS));
    send_op(op_of(ACT_TEST_WIN, 0, '0, 128, 72));
    send_op(op_of(ACT_TEST_WIN, 0, '0, 0, MAX_POS));
    settle();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin bases = MAX_POS; use_bitmap = 1'b1; end
        1: begin bases = $urandom_range(1, MAX_POS - 1); use_bitmap = 1'b0; end
        2: begin bases = 0; use_bitmap = 1'b1; end
        3: begin bases = $urandom_range(1, 600); use_bitmap = 1'b1; end
        4: begin bases = MAX_POS; use_bitmap = 1'b0; end
        default: begin bases = WORD_BITS * $urandom_range(1, 16); use_bitmap = 1'b1; end
      endcase
      if (phase == 2) begin
        send_idle_pct = 47;
        recv_idle_pct = 33;
      end
      if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_config(bases, use_bitmap);
      words = (bases + WORD_BITS - 1) / WORD_BITS;
      // cluster at the end of the sequence half the time
      if (words <= CLUSTER_WORDS) clus_lo = 0;
      else if ($urandom_range(0, 1) == 0) clus_lo = words - CLUSTER_WORDS;
      else clus_lo = $urandom_range(0, words - CLUSTER_WORDS);
      repeat (PHASE_ITEMS) send_op(random_op(clus_lo));
      settle();
    end

    $display("Covered %0d writes, %0d masked reads, %0d base tests, %0d window tests, %0d settings",
             sb.per_action[ACT_WRITE], sb.per_action[ACT_READ],
             sb.per_action[ACT_TEST_BASE], sb.per_action[ACT_TEST_WIN], NUM_PHASES + 1);
    $display("%0d results compared, %0d tests found valid, %0d mismatches",
             sb.results_seen, sb.valid_results, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
